>>> rtl/ffft_pkg.sv
// Package for the fixed-point FFT block: shared types, constants and twiddle table.
// Used by every module of the block; depends on nothing.
package ffft_pkg;

   localparam int unsigned NPoints = 256;
   localparam int unsigned SampleWidth = 22;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned TwWidth = 17;
   localparam int unsigned GroupWidth = 6;

   typedef logic signed [WordWidth-1:0] word_type;

   // One sample as it travels from the front end to the engine.
   typedef struct packed {
      logic signed [SampleWidth-1:0] re;
      logic signed [SampleWidth-1:0] im;
      logic bad;
   } sample_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_PAD, ST_FFT, ST_DRAIN, ST_EMIT
   } eng_state_type;

   // Q15 twiddle: cos and -sin of 2*pi*i/256.
   function automatic logic signed [2*TwWidth-1:0] twiddle(input logic [6:0] idx);
      logic signed [TwWidth-1:0] c;
      logic signed [TwWidth-1:0] s;
      case (idx)
         7'd0: begin c = 17'sd32768; s = 17'sd0; end
         7'd1: begin c = 17'sd32758; s = -17'sd804; end
         7'd2: begin c = 17'sd32729; s = -17'sd1608; end
         7'd3: begin c = 17'sd32679; s = -17'sd2411; end
         7'd4: begin c = 17'sd32610; s = -17'sd3212; end
         7'd5: begin c = 17'sd32522; s = -17'sd4011; end
         7'd6: begin c = 17'sd32413; s = -17'sd4808; end
         7'd7: begin c = 17'sd32286; s = -17'sd5602; end
         7'd8: begin c = 17'sd32138; s = -17'sd6393; end
         7'd9: begin c = 17'sd31972; s = -17'sd7180; end
         7'd10: begin c = 17'sd31786; s = -17'sd7962; end
         7'd11: begin c = 17'sd31581; s = -17'sd8740; end
         7'd12: begin c = 17'sd31357; s = -17'sd9512; end
         7'd13: begin c = 17'sd31114; s = -17'sd10279; end
         7'd14: begin c = 17'sd30853; s = -17'sd11039; end
         7'd15: begin c = 17'sd30572; s = -17'sd11793; end
         7'd16: begin c = 17'sd30274; s = -17'sd12540; end
         7'd17: begin c = 17'sd29957; s = -17'sd13279; end
         7'd18: begin c = 17'sd29622; s = -17'sd14010; end
         7'd19: begin c = 17'sd29269; s = -17'sd14733; end
         7'd20: begin c = 17'sd28899; s = -17'sd15447; end
         7'd21: begin c = 17'sd28511; s = -17'sd16151; end
         7'd22: begin c = 17'sd28106; s = -17'sd16846; end
         7'd23: begin c = 17'sd27684; s = -17'sd17531; end
         7'd24: begin c = 17'sd27246; s = -17'sd18205; end
         7'd25: begin c = 17'sd26791; s = -17'sd18868; end
         7'd26: begin c = 17'sd26320; s = -17'sd19520; end
         7'd27: begin c = 17'sd25833; s = -17'sd20160; end
         7'd28: begin c = 17'sd25330; s = -17'sd20788; end
         7'd29: begin c = 17'sd24812; s = -17'sd21403; end
         7'd30: begin c = 17'sd24279; s = -17'sd22006; end
         7'd31: begin c = 17'sd23732; s = -17'sd22595; end
         7'd32: begin c = 17'sd23170; s = -17'sd23170; end
         7'd33: begin c = 17'sd22595; s = -17'sd23732; end
         7'd34: begin c = 17'sd22006; s = -17'sd24279; end
         7'd35: begin c = 17'sd21403; s = -17'sd24812; end
         7'd36: begin c = 17'sd20788; s = -17'sd25330; end
         7'd37: begin c = 17'sd20160; s = -17'sd25833; end
         7'd38: begin c = 17'sd19520; s = -17'sd26320; end
         7'd39: begin c = 17'sd18868; s = -17'sd26791; end
         7'd40: begin c = 17'sd18205; s = -17'sd27246; end
         7'd41: begin c = 17'sd17531; s = -17'sd27684; end
         7'd42: begin c = 17'sd16846; s = -17'sd28106; end
         7'd43: begin c = 17'sd16151; s = -17'sd28511; end
         7'd44: begin c = 17'sd15447; s = -17'sd28899; end
         7'd45: begin c = 17'sd14733; s = -17'sd29269; end
         7'd46: begin c = 17'sd14010; s = -17'sd29622; end
         7'd47: begin c = 17'sd13279; s = -17'sd29957; end
         7'd48: begin c = 17'sd12540; s = -17'sd30274; end
         7'd49: begin c = 17'sd11793; s = -17'sd30572; end
         7'd50: begin c = 17'sd11039; s = -17'sd30853; end
         7'd51: begin c = 17'sd10279; s = -17'sd31114; end
         7'd52: begin c = 17'sd9512; s = -17'sd31357; end
         7'd53: begin c = 17'sd8740; s = -17'sd31581; end
         7'd54: begin c = 17'sd7962; s = -17'sd31786; end
         7'd55: begin c = 17'sd7180; s = -17'sd31972; end
         7'd56: begin c = 17'sd6393; s = -17'sd32138; end
         7'd57: begin c = 17'sd5602; s = -17'sd32286; end
         7'd58: begin c = 17'sd4808; s = -17'sd32413; end
         7'd59: begin c = 17'sd4011; s = -17'sd32522; end
         7'd60: begin c = 17'sd3212; s = -17'sd32610; end
         7'd61: begin c = 17'sd2411; s = -17'sd32679; end
         7'd62: begin c = 17'sd1608; s = -17'sd32729; end
         7'd63: begin c = 17'sd804; s = -17'sd32758; end
         7'd64: begin c = 17'sd0; s = -17'sd32768; end
         7'd65: begin c = -17'sd804; s = -17'sd32758; end
         7'd66: begin c = -17'sd1608; s = -17'sd32729; end
         7'd67: begin c = -17'sd2411; s = -17'sd32679; end
         7'd68: begin c = -17'sd3212; s = -17'sd32610; end
         7'd69: begin c = -17'sd4011; s = -17'sd32522; end
         7'd70: begin c = -17'sd4808; s = -17'sd32413; end
         7'd71: begin c = -17'sd5602; s = -17'sd32286; end
         7'd72: begin c = -17'sd6393; s = -17'sd32138; end
         7'd73: begin c = -17'sd7180; s = -17'sd31972; end
         7'd74: begin c = -17'sd7962; s = -17'sd31786; end
         7'd75: begin c = -17'sd8740; s = -17'sd31581; end
         7'd76: begin c = -17'sd9512; s = -17'sd31357; end
         7'd77: begin c = -17'sd10279; s = -17'sd31114; end
         7'd78: begin c = -17'sd11039; s = -17'sd30853; end
         7'd79: begin c = -17'sd11793; s = -17'sd30572; end
         7'd80: begin c = -17'sd12540; s = -17'sd30274; end
         7'd81: begin c = -17'sd13279; s = -17'sd29957; end
         7'd82: begin c = -17'sd14010; s = -17'sd29622; end
         7'd83: begin c = -17'sd14733; s = -17'sd29269; end
         7'd84: begin c = -17'sd15447; s = -17'sd28899; end
         7'd85: begin c = -17'sd16151; s = -17'sd28511; end
         7'd86: begin c = -17'sd16846; s = -17'sd28106; end
         7'd87: begin c = -17'sd17531; s = -17'sd27684; end
         7'd88: begin c = -17'sd18205; s = -17'sd27246; end
         7'd89: begin c = -17'sd18868; s = -17'sd26791; end
         7'd90: begin c = -17'sd19520; s = -17'sd26320; end
         7'd91: begin c = -17'sd20160; s = -17'sd25833; end
         7'd92: begin c = -17'sd20788; s = -17'sd25330; end
         7'd93: begin c = -17'sd21403; s = -17'sd24812; end
         7'd94: begin c = -17'sd22006; s = -17'sd24279; end
         7'd95: begin c = -17'sd22595; s = -17'sd23732; end
         7'd96: begin c = -17'sd23170; s = -17'sd23170; end
         7'd97: begin c = -17'sd23732; s = -17'sd22595; end
         7'd98: begin c = -17'sd24279; s = -17'sd22006; end
         7'd99: begin c = -17'sd24812; s = -17'sd21403; end
         7'd100: begin c = -17'sd25330; s = -17'sd20788; end
         7'd101: begin c = -17'sd25833; s = -17'sd20160; end
         7'd102: begin c = -17'sd26320; s = -17'sd19520; end
         7'd103: begin c = -17'sd26791; s = -17'sd18868; end
         7'd104: begin c = -17'sd27246; s = -17'sd18205; end
         7'd105: begin c = -17'sd27684; s = -17'sd17531; end
         7'd106: begin c = -17'sd28106; s = -17'sd16846; end
         7'd107: begin c = -17'sd28511; s = -17'sd16151; end
         7'd108: begin c = -17'sd28899; s = -17'sd15447; end
         7'd109: begin c = -17'sd29269; s = -17'sd14733; end
         7'd110: begin c = -17'sd29622; s = -17'sd14010; end
         7'd111: begin c = -17'sd29957; s = -17'sd13279; end
         7'd112: begin c = -17'sd30274; s = -17'sd12540; end
         7'd113: begin c = -17'sd30572; s = -17'sd11793; end
         7'd114: begin c = -17'sd30853; s = -17'sd11039; end
         7'd115: begin c = -17'sd31114; s = -17'sd10279; end
         7'd116: begin c = -17'sd31357; s = -17'sd9512; end
         7'd117: begin c = -17'sd31581; s = -17'sd8740; end
         7'd118: begin c = -17'sd31786; s = -17'sd7962; end
         7'd119: begin c = -17'sd31972; s = -17'sd7180; end
         7'd120: begin c = -17'sd32138; s = -17'sd6393; end
         7'd121: begin c = -17'sd32286; s = -17'sd5602; end
         7'd122: begin c = -17'sd32413; s = -17'sd4808; end
         7'd123: begin c = -17'sd32522; s = -17'sd4011; end
         7'd124: begin c = -17'sd32610; s = -17'sd3212; end
         7'd125: begin c = -17'sd32679; s = -17'sd2411; end
         7'd126: begin c = -17'sd32729; s = -17'sd1608; end
         7'd127: begin c = -17'sd32758; s = -17'sd804; end
         default: begin c = 17'sd0; s = 17'sd0; end
      endcase
      return {c, s};
   endfunction

endpackage

>>> rtl/ffft_front.sv
// Front end of the FFT block: takes samples, checks the input contract, queues them.
// Uses ffft_pkg for the sample type.
module ffft_front #(
   parameter int unsigned InputLimit = 1048576,
   parameter int unsigned QueueDepth = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [ffft_pkg::SampleWidth-1:0] in_re,
   input  logic signed [ffft_pkg::SampleWidth-1:0] in_im,
   input  logic in_bad,
   output logic full,
   output logic q_valid,
   output ffft_pkg::sample_type q_data,
   input  logic q_pop
);
   localparam int unsigned PtrWidth = $clog2(QueueDepth);
   localparam logic signed [ffft_pkg::SampleWidth:0] LimHi = (ffft_pkg::SampleWidth+1)'(InputLimit);
   localparam logic signed [ffft_pkg::SampleWidth:0] LimLo = -LimHi;

   ffft_pkg::sample_type mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrWidth:0] cnt_ff, cnt_in;
   logic push;
   logic over;
   logic signed [ffft_pkg::SampleWidth:0] re_x, im_x;

   // Range check on the sign-extended sample.
   always_comb begin
      re_x = {in_re[ffft_pkg::SampleWidth-1], in_re};
      im_x = {in_im[ffft_pkg::SampleWidth-1], in_im};
      over = in_bad || re_x > LimHi || re_x < LimLo || im_x > LimHi || im_x < LimLo;
   end

   assign push = in_valid && !full;
   assign full = (cnt_ff == (PtrWidth+1)'(QueueDepth));
   assign q_valid = (cnt_ff != '0);
   assign q_data = mem_ff[rd_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrWidth'(QueueDepth-1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         rd_in = (rd_ff == PtrWidth'(QueueDepth-1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{re: in_re, im: in_im, bad: over};
      end
   end
endmodule

>>> rtl/ffft_engine.sv
// Back end of the FFT block: buffer memory, butterfly unit and result sequencing.
// Uses ffft_pkg for types, state codes, the transform size and the twiddle table.
module ffft_engine #(
   parameter int unsigned NInput = 128
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  ffft_pkg::sample_type q_data,
   output logic q_pop,
   output logic out_valid,
   output ffft_pkg::word_type out_re [4],
   output ffft_pkg::word_type out_im [4],
   output logic [ffft_pkg::GroupWidth-1:0] out_group,
   output logic out_last,
   output logic out_err,
   output logic active
);
   localparam int unsigned NPoints = ffft_pkg::NPoints;
   localparam int unsigned Bits = $clog2(NPoints);
   localparam int unsigned Groups = NPoints / 4;
   localparam int unsigned GW = $clog2(Groups);
   localparam int unsigned CntW = $clog2(NInput + 1);
   localparam int unsigned SW = $clog2(Bits + 1);

   // Four banks indexed by address[1:0], each holding NPoints/4 words.
   logic [2*ffft_pkg::WordWidth-1:0] bank0 [Groups];
   logic [2*ffft_pkg::WordWidth-1:0] bank1 [Groups];
   logic [2*ffft_pkg::WordWidth-1:0] bank2 [Groups];
   logic [2*ffft_pkg::WordWidth-1:0] bank3 [Groups];

   ffft_pkg::eng_state_type st_ff, st_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic err_ff, err_in;
   logic [Bits-1:0] idx_ff, idx_in;      // pad address or butterfly index
   logic [SW-1:0] stg_ff, stg_in;        // stage 1..Bits
   logic [GW-1:0] grp_ff, grp_in;
   logic [1:0] ph_ff, ph_in;             // butterfly phase
   logic [2:0] dr_ff, dr_in;

   // Butterfly datapath registers.
   logic [Bits-1:0] pa_ff, pb_ff;
   logic [6:0] tw_ff;
   ffft_pkg::word_type ar_ff, ai_ff;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   ffft_pkg::word_type tr, ti;

   // Memory port signals.
   logic we;
   logic [Bits-1:0] waddr;
   logic [2*ffft_pkg::WordWidth-1:0] wdata;
   logic [Bits-1:0] raddr;
   logic [2*ffft_pkg::WordWidth-1:0] rdata;
   logic [2*ffft_pkg::WordWidth-1:0] rd0_ff, rd1_ff, rd2_ff, rd3_ff;
   logic [GW-1:0] gaddr;

   function automatic logic [Bits-1:0] brev(input logic [Bits-1:0] v);
      logic [Bits-1:0] r;
      for (int k = 0; k < Bits; k++) begin
         r[k] = v[Bits-1-k];
      end
      return r;
   endfunction

   logic [Bits-1:0] half, tpos, j0, ia, ib;
   logic [Bits-1:0] twn;
   logic signed [2*ffft_pkg::TwWidth-1:0] tw_pair;
   logic signed [ffft_pkg::TwWidth-1:0] tc, ts;
   logic signed [63:0] sr, si;
   logic [Bits-1:0] load_addr;

   // Butterfly addressing for index idx_ff in stage stg_ff.
   always_comb begin
      half = Bits'(1) << (stg_ff - 1'b1);
      tpos = idx_ff & (half - 1'b1);
      j0 = (idx_ff & ~(half - 1'b1)) << 1;
      ia = j0 | tpos;
      ib = ia | half;
      twn = tpos << (Bits - 32'(stg_ff));
      load_addr = brev(cnt_ff[Bits-1:0]);
   end

   // Twiddle lookup and rounding of the registered products.
   always_comb begin
      tw_pair = ffft_pkg::twiddle(tw_ff);
      tc = tw_pair[2*ffft_pkg::TwWidth-1:ffft_pkg::TwWidth];
      ts = tw_pair[ffft_pkg::TwWidth-1:0];
      sr = p0_ff - p1_ff + 64'sd16384;
      si = p2_ff + p3_ff + 64'sd16384;
      tr = sr[46:15];
      ti = si[46:15];
   end

   // Sequencer: load, pad, butterflies in four phases, drain, emit.
   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      err_in = err_ff;
      idx_in = idx_ff;
      stg_in = stg_ff;
      grp_in = grp_ff;
      ph_in = ph_ff;
      dr_in = dr_ff;
      q_pop = 1'b0;
      we = 1'b0;
      waddr = '0;
      wdata = '0;
      raddr = ia;
      out_valid = 1'b0;
      case (st_ff)
         ffft_pkg::ST_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               we = 1'b1;
               waddr = load_addr;
               wdata = {32'(q_data.re), 32'(q_data.im)};
               err_in = err_ff | q_data.bad;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CntW'(NInput - 1)) begin
                  st_in = ffft_pkg::ST_PAD;
                  idx_in = '0;
               end
            end
         end
         ffft_pkg::ST_PAD: begin
            if (32'(brev(idx_ff)) >= NInput) begin
               we = 1'b1;
               waddr = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == Bits'(NPoints - 1)) begin
               st_in = ffft_pkg::ST_FFT;
               stg_in = SW'(1);
               idx_in = '0;
               ph_in = '0;
            end
         end
         ffft_pkg::ST_FFT: begin
            // Phase 0 reads b, phase 1 reads a while the b products are formed,
            // phase 2 writes the sum and phase 3 the difference.
            ph_in = ph_ff + 1'b1;
            case (ph_ff)
               2'd0: raddr = ib;
               2'd1: raddr = ia;
               2'd2: begin
                  we = 1'b1;
                  waddr = pa_ff;
                  wdata = {rdata[63:32] + tr, rdata[31:0] + ti};
               end
               default: begin
                  we = 1'b1;
                  waddr = pb_ff;
                  wdata = {ar_ff - tr, ai_ff - ti};
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == Bits'(NPoints/2 - 1)) begin
                     idx_in = '0;
                     stg_in = stg_ff + 1'b1;
                     if (stg_ff == SW'(Bits)) begin
                        st_in = ffft_pkg::ST_DRAIN;
                        grp_in = '0;
                        dr_in = '0;
                     end
                  end
               end
            endcase
         end
         ffft_pkg::ST_DRAIN: begin
            st_in = ffft_pkg::ST_EMIT;
         end
         ffft_pkg::ST_EMIT: begin
            if (dr_ff == 3'd1) begin
               out_valid = 1'b1;
               grp_in = grp_ff + 1'b1;
               if (grp_ff == GW'(Groups - 1)) begin
                  st_in = ffft_pkg::ST_LOAD;
                  cnt_in = '0;
                  err_in = 1'b0;
               end
            end
            dr_in = (dr_ff == 3'd1) ? 3'd0 : 3'd1;
         end
         default: st_in = ffft_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ffft_pkg::ST_LOAD;
         cnt_ff <= '0;
         err_ff <= 1'b0;
         idx_ff <= '0;
         stg_ff <= SW'(1);
         grp_ff <= '0;
         ph_ff <= '0;
         dr_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         err_ff <= err_in;
         idx_ff <= idx_in;
         stg_ff <= stg_in;
         grp_ff <= grp_in;
         ph_ff <= ph_in;
         dr_ff <= dr_in;
      end
   end

   // Butterfly addresses and twiddle are latched in phase 0; the a word lands
   // in phase 2 and is kept for the difference written in phase 3.
   always_ff @(posedge clock) begin
      if (st_ff == ffft_pkg::ST_FFT) begin
         case (ph_ff)
            2'd0: begin
               pa_ff <= ia;
               pb_ff <= ib;
               tw_ff <= twn[6:0];
            end
            2'd2: begin
               ar_ff <= rdata[63:32];
               ai_ff <= rdata[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   ffft_pkg::word_type brr, bii;
   assign brr = rdata[63:32];
   assign bii = rdata[31:0];

   // The b word lands in phase 1; its products are held through phases 2 and 3.
   always_ff @(posedge clock) begin
      if (st_ff == ffft_pkg::ST_FFT && ph_ff == 2'd1) begin
         p0_ff <= 64'(brr) * 64'(tc);
         p1_ff <= 64'(bii) * 64'(ts);
         p2_ff <= 64'(bii) * 64'(tc);
         p3_ff <= 64'(brr) * 64'(ts);
      end
   end

   // Banked memory: one write and one read per cycle; emit reads all four banks.
   assign gaddr = (st_ff == ffft_pkg::ST_EMIT) ? grp_ff : raddr[Bits-1:2];
   always_ff @(posedge clock) begin
      if (we) begin
         case (waddr[1:0])
            2'd0: bank0[waddr[Bits-1:2]] <= wdata;
            2'd1: bank1[waddr[Bits-1:2]] <= wdata;
            2'd2: bank2[waddr[Bits-1:2]] <= wdata;
            default: bank3[waddr[Bits-1:2]] <= wdata;
         endcase
      end
      rd0_ff <= bank0[gaddr];
      rd1_ff <= bank1[gaddr];
      rd2_ff <= bank2[gaddr];
      rd3_ff <= bank3[gaddr];
   end

   logic [1:0] rsel_ff;
   always_ff @(posedge clock) begin
      rsel_ff <= raddr[1:0];
   end

   always_comb begin
      case (rsel_ff)
         2'd0: rdata = rd0_ff;
         2'd1: rdata = rd1_ff;
         2'd2: rdata = rd2_ff;
         default: rdata = rd3_ff;
      endcase
   end

   // Result fields come straight from the registered bank reads.
   always_comb begin
      out_re[0] = rd0_ff[63:32]; out_im[0] = rd0_ff[31:0];
      out_re[1] = rd1_ff[63:32]; out_im[1] = rd1_ff[31:0];
      out_re[2] = rd2_ff[63:32]; out_im[2] = rd2_ff[31:0];
      out_re[3] = rd3_ff[63:32]; out_im[3] = rd3_ff[31:0];
      out_group = ffft_pkg::GroupWidth'(grp_ff);
      out_last = (grp_ff == GW'(Groups - 1));
      out_err = err_ff;
      active = (st_ff != ffft_pkg::ST_LOAD);
   end
endmodule

>>> rtl/fixed_point_fft_256.sv
// Top level of the 256-point fixed-point FFT: front end queue plus FFT engine.
// Depends on ffft_pkg, ffft_front and ffft_engine.
//
// Usage: drive req_sample_re/im/bad with start high; a sample transfers on a
// rising edge with start high and busy low. After the 128th sample the engine
// zero-pads the buffer, runs 1024 butterflies on one shared multiplier unit
// with one memory read port and one write port, and then emits 64 results,
// each marked by rsp_valid for one cycle. Samples transfer one per cycle
// while the engine is loading. busy is high while the sample queue is full,
// which it becomes during the transform. The receiver cannot stall: each
// result must be taken in its cycle. Reset is synchronous and clears the
// sample count, the error flag and the queue; the buffer contents need no
// clearing since every entry is written before it is read.
module fixed_point_fft_256 #(
   parameter int unsigned N_INPUT = 128,
   parameter int unsigned INPUT_LIMIT = 1048576
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [21:0] req_sample_re,
   input  logic signed [21:0] req_sample_im,
   input  logic req_sample_bad,
   output logic rsp_valid,
   output logic signed [31:0] rsp_bin0_re,
   output logic signed [31:0] rsp_bin0_im,
   output logic signed [31:0] rsp_bin1_re,
   output logic signed [31:0] rsp_bin1_im,
   output logic signed [31:0] rsp_bin2_re,
   output logic signed [31:0] rsp_bin2_im,
   output logic signed [31:0] rsp_bin3_re,
   output logic signed [31:0] rsp_bin3_im,
   output logic [5:0] rsp_group_index,
   output logic rsp_last_group,
   output logic rsp_contract_error
);
   logic full, q_valid, q_pop, active;
   ffft_pkg::sample_type q_data;
   ffft_pkg::word_type o_re [4];
   ffft_pkg::word_type o_im [4];

   ffft_front #(.InputLimit(INPUT_LIMIT), .QueueDepth(4)) u_front (
      .clock(clock), .reset(reset), .in_valid(start),
      .in_re(req_sample_re), .in_im(req_sample_im), .in_bad(req_sample_bad),
      .full(full), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
   );

   ffft_engine #(.NInput(N_INPUT)) u_engine (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
      .out_valid(rsp_valid), .out_re(o_re), .out_im(o_im),
      .out_group(rsp_group_index), .out_last(rsp_last_group),
      .out_err(rsp_contract_error), .active(active)
   );

   assign busy = full;
   assign rsp_bin0_re = o_re[0]; assign rsp_bin0_im = o_im[0];
   assign rsp_bin1_re = o_re[1]; assign rsp_bin1_im = o_im[1];
   assign rsp_bin2_re = o_re[2]; assign rsp_bin2_im = o_im[2];
   assign rsp_bin3_re = o_re[3]; assign rsp_bin3_im = o_im[3];

   // The queue is never drained while the engine is busy with a frame.
   a_no_pop_active: assert property (@(posedge clock) disable iff (reset)
      active |-> !q_pop) else $error("sample popped during transform");
   // Results only appear while the engine is active.
   a_out_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> active) else $error("result outside emit phase");
   // The last group ends the frame and the engine returns to loading.
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_group |=> !active) else $error("frame did not end");
endmodule

>>> tb/fft256_checker.sv
// Result checker for the 256-point FFT: watches both transfers, predicts each frame's bins.
// Depends on ffft_pkg; instantiated beside the block by tb_fixed_point_fft_256.
module fft256_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic signed [21:0] req_sample_re,
   input  logic signed [21:0] req_sample_im,
   input  logic req_sample_bad,
   input  logic rsp_valid,
   input  logic signed [31:0] rsp_bin0_re,
   input  logic signed [31:0] rsp_bin0_im,
   input  logic signed [31:0] rsp_bin1_re,
   input  logic signed [31:0] rsp_bin1_im,
   input  logic signed [31:0] rsp_bin2_re,
   input  logic signed [31:0] rsp_bin2_im,
   input  logic signed [31:0] rsp_bin3_re,
   input  logic signed [31:0] rsp_bin3_im,
   input  logic [5:0] rsp_group_index,
   input  logic rsp_last_group,
   input  logic rsp_contract_error,
   output int error_count,
   output int pending_count,
   output int results_seen
);
   localparam int Limit = 1048576;

   typedef struct packed {
      logic [3:0][31:0] re;
      logic [3:0][31:0] im;
      logic [5:0] group;
      logic last;
      logic err;
   } bin_group_type;

   // First quadrant of the Q15 cosine; the rest of the table follows by symmetry.
   localparam int CosQuarter[65] = '{
      32768, 32758, 32729, 32679, 32610, 32522, 32413, 32286, 32138, 31972,
      31786, 31581, 31357, 31114, 30853, 30572, 30274, 29957, 29622, 29269,
      28899, 28511, 28106, 27684, 27246, 26791, 26320, 25833, 25330, 24812,
      24279, 23732, 23170, 22595, 22006, 21403, 20788, 20160, 19520, 18868,
      18205, 17531, 16846, 16151, 15447, 14733, 14010, 13279, 12540, 11793,
      11039, 10279, 9512, 8740, 7962, 7180, 6393, 5602, 4808, 4011,
      3212, 2411, 1608, 804, 0};

   ffft_pkg::word_type spec_re[256];
   ffft_pkg::word_type spec_im[256];
   int unsigned samples_loaded;
   bit frame_bad;
   bin_group_type bins_q[$];

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) r[7-k] = v[k];
      return r;
   endfunction

   // Radix-2 decimation in time over the bit-reversed buffer, no stage scaling.
   task automatic transform_frame();
      int unsigned m;
      int unsigned half;
      int unsigned idx;
      int unsigned a;
      int unsigned b;
      longint tc;
      longint ts;
      longint br;
      longint bi;
      ffft_pkg::word_type tr;
      ffft_pkg::word_type ti;
      ffft_pkg::word_type ar;
      ffft_pkg::word_type ai;
      for (int i = 0; i < 256; i++) begin
         if (reverse8(8'(i)) >= 128) begin
            spec_re[i] = '0;
            spec_im[i] = '0;
         end
      end
      for (int s = 1; s <= 8; s++) begin
         m = 1 << s;
         half = m >> 1;
         for (int j0 = 0; j0 < 256; j0 += m) begin
            for (int t = 0; t < half; t++) begin
               idx = ((t * 256) / m) & 127;
               tc = (idx <= 64) ? CosQuarter[idx] : -CosQuarter[128-idx];
               ts = (idx <= 64) ? -CosQuarter[64-idx] : -CosQuarter[idx-64];
               a = j0 + t;
               b = a + half;
               br = spec_re[b];
               bi = spec_im[b];
               // Round to nearest with ties upward: add half, then floor-shift.
               tr = ffft_pkg::word_type'((br * tc - bi * ts + 64'sd16384) >>> 15);
               ti = ffft_pkg::word_type'((bi * tc + br * ts + 64'sd16384) >>> 15);
               ar = spec_re[a];
               ai = spec_im[a];
               spec_re[a] = ar + tr;
               spec_im[a] = ai + ti;
               spec_re[b] = ar - tr;
               spec_im[b] = ai - ti;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      bin_group_type want;
      bin_group_type got;
      int re_i;
      int im_i;
      if (reset) begin
         samples_loaded = 0;
         frame_bad = 0;
         error_count = 0;
         results_seen = 0;
         bins_q.delete();
      end else begin
         // Sample transfer: store at its bit-reversed slot, track the contract flag.
         if (start && !busy) begin
            re_i = req_sample_re;
            im_i = req_sample_im;
            if (req_sample_bad || re_i > Limit || re_i < -Limit || im_i > Limit ||
                  im_i < -Limit)
               frame_bad = 1;
            spec_re[reverse8(8'(samples_loaded))] = re_i;
            spec_im[reverse8(8'(samples_loaded))] = im_i;
            samples_loaded++;
            if (samples_loaded == 128) begin
               transform_frame();
               for (int g = 0; g < 64; g++) begin
                  for (int k = 0; k < 4; k++) begin
                     want.re[k] = spec_re[4*g+k];
                     want.im[k] = spec_im[4*g+k];
                  end
                  want.group = 6'(g);
                  want.last = (g == 63);
                  want.err = frame_bad;
                  bins_q.push_back(want);
               end
               samples_loaded = 0;
               frame_bad = 0;
            end
         end
         // Result transfer: compare with the oldest expected group.
         if (rsp_valid) begin
            results_seen++;
            got.re = {rsp_bin3_re, rsp_bin2_re, rsp_bin1_re, rsp_bin0_re};
            got.im = {rsp_bin3_im, rsp_bin2_im, rsp_bin1_im, rsp_bin0_im};
            got.group = rsp_group_index;
            got.last = rsp_last_group;
            got.err = rsp_contract_error;
            if (bins_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("Unexpected result transfer: group %0d", rsp_group_index);
            end else begin
               want = bins_q.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("Mismatch in group %0d:", want.group);
                     $display("  expected re %h im %h grp %0d last %b err %b",
                        want.re, want.im, want.group, want.last, want.err);
                     $display("  actual   re %h im %h grp %0d last %b err %b",
                        got.re, got.im, got.group, got.last, got.err);
                  end
               end
            end
         end
      end
      pending_count = bins_q.size();
   end

endmodule

>>> tb/tb_fixed_point_fft_256.sv
// Testbench top for the 256-point FFT: makes sample stimulus and gives the verdict.
// Depends on ffft_pkg, fixed_point_fft_256 and fft256_checker.
module tb_fixed_point_fft_256;
   localparam int Limit = 1048576;
   localparam int WatchdogLimit = 40000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [21:0] req_sample_re = '0;
   logic signed [21:0] req_sample_im = '0;
   logic req_sample_bad = 0;
   logic rsp_valid;
   logic signed [31:0] rsp_bin0_re, rsp_bin0_im, rsp_bin1_re, rsp_bin1_im;
   logic signed [31:0] rsp_bin2_re, rsp_bin2_im, rsp_bin3_re, rsp_bin3_im;
   logic [5:0] rsp_group_index;
   logic rsp_last_group;
   logic rsp_contract_error;
   int error_count;
   int pending_count;
   int results_seen;
   int samples_sent = 0;
   int quiet_cycles = 0;
   bit gaps_on = 1;

   always #2 clock = ~clock;

   fixed_point_fft_256 uut (.*);
   fft256_checker check (.*);

   // Watchdog: counts cycles in which neither channel makes a transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_fixed_point_fft_256 NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one sample from a falling edge and returns at the falling edge after its transfer.
   task automatic send_sample(input int re, input int im, input bit bad);
      while (gaps_on && $urandom_range(99) < 27) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_sample_re <= 22'(re);
      req_sample_im <= 22'(im);
      req_sample_bad <= bad;
      do @(posedge clock); while (busy);
      samples_sent++;
      @(negedge clock);
   endtask

   // Mostly in-contract values; sometimes any 22-bit pattern.
   function automatic int rand_part(input bit wild);
      if (wild) return int'($urandom);
      return int'($urandom_range(2 * Limit)) - Limit;
   endfunction

   task automatic random_frame(input int count, input int wild_pct, input bit allow_bad);
      for (int i = 0; i < count; i++)
         send_sample(rand_part($urandom_range(99) < wild_pct),
            rand_part($urandom_range(99) < wild_pct),
            allow_bad && $urandom_range(99) < 3);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Frame one: field extremes, contract edges and the explicit bad flag first.
      send_sample(Limit, Limit, 0);
      send_sample(-Limit, -Limit, 0);
      send_sample(Limit + 1, 0, 0);
      send_sample(0, -Limit - 1, 0);
      send_sample(22'h200000, 22'h1FFFFF, 0);
      send_sample(22'h1FFFFF, 22'h200000, 0);
      send_sample(0, 0, 1);
      send_sample(1, -1, 0);
      send_sample(22'h2AAAAA, 22'h155555, 0);
      send_sample(22'h155555, 22'h2AAAAA, 1);
      send_sample(22'h3FFFFF, 0, 0);
      send_sample(Limit, -Limit, 0);
      for (int i = 0; i < 8; i++) send_sample(Limit, Limit, 0);
      random_frame(108, 15, 1);

      // Frame two: clean samples with no gaps, so the error flag must have cleared.
      gaps_on = 0;
      random_frame(128, 0, 0);
      start <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d samples in %0d frames; checked %0d result groups.",
         samples_sent, samples_sent / 128, results_seen);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_fixed_point_fft_256 OK");
      end else begin
         $display("tb_fixed_point_fft_256 NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/ffft_pkg.sv
rtl/ffft_front.sv
rtl/ffft_engine.sv
rtl/fixed_point_fft_256.sv
tb/fft256_checker.sv
tb/tb_fixed_point_fft_256.sv
